// ===== rtl/core/rac_pkg.sv =====
`default_nettype none

package rac_pkg;

	localparam int POS_W = 8;

	// Largest byte count that allocate accepts.
	localparam logic [3:0] MAX_BYTES = 4'd12;

	// Action codes
	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_REMOVE  = 2'd1;
	localparam logic [1:0] ACT_COMPACT = 2'd2;
	localparam logic [1:0] ACT_READ    = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_ROOM  = 2'd1;
	localparam logic [1:0] STAT_NO_BLOCK = 2'd2;
	localparam logic [1:0] STAT_RANGE    = 2'd3;

	// One row of the store together with its frame entry.
	typedef struct packed {
		logic [31:0] word;
		logic        start;
		logic [3:0]  len;
	} rac_row_t;

	// Rows spanned by a block of len bytes; a zero length still covers one row.
	function automatic logic [2:0] rows_of(input logic [3:0] len);
		logic [4:0] sum;
		begin
			sum = {1'b0, len} + 5'd3;
			if (len == 4'd0) begin
				rows_of = 3'd1;
			end else begin
				rows_of = sum[4:2];
			end
		end
	endfunction

	// Keep the low bytes of a row word; four or more keeps the whole word.
	function automatic logic [31:0] byte_mask(input logic [3:0] bytes);
		begin
			unique case (bytes)
				4'd0: byte_mask = 32'h0000_0000;
				4'd1: byte_mask = 32'h0000_00FF;
				4'd2: byte_mask = 32'h0000_FFFF;
				4'd3: byte_mask = 32'h00FF_FFFF;
				default: byte_mask = 32'hFFFF_FFFF;
			endcase
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rac_mem.sv =====
`default_nettype none

// Row store: one synchronous read port, one write port, read data registered.
// Per-row valid bits make a never-written row read as zero after reset.
module rac_mem #(
	parameter int ROWS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rd_en,
	input  wire logic [$clog2(ROWS)-1:0]   rd_addr,
	output rac_pkg::rac_row_t              rd_data,
	input  wire logic                      wr_en,
	input  wire logic [$clog2(ROWS)-1:0]   wr_addr,
	input  wire rac_pkg::rac_row_t         wr_data
);

	rac_pkg::rac_row_t mem [ROWS];
	rac_pkg::rac_row_t rd_raw_q;
	logic [ROWS-1:0]   valid_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/row_allocator_with_compaction.sv =====
`default_nettype none

// Row allocator with compaction. Holds ROWS four-byte rows, each with a frame
// entry (block-start flag, block length), in one single-port-style memory whose
// read data is registered and which is written back by a small sequencer; one
// command beat is worked at a time and gives exactly one result beat. A new
// command is taken while the previous result still waits on the output. Each
// row is read, checked and written back through the one memory port. Errors
// (range, bad length, no room, no block) go to the result as soon as they are
// found. Reset clears a valid bit per row at once, so there is no clearing
// pass and commands are taken right after reset.
module row_allocator_with_compaction #(
	parameter int ROWS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  position,
	input  wire logic [3:0]  length,
	input  wire logic [31:0] word_first,
	input  wire logic [31:0] word_second,
	input  wire logic [31:0] word_third,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      row_word,
	output logic             block_start,
	output logic [3:0]       block_length
);

	localparam int AW = $clog2(ROWS);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] ROWS_C = CW'(ROWS);
	localparam logic [rac_pkg::POS_W:0] ROWS_P = (rac_pkg::POS_W + 1)'(ROWS);

	// Sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ARD   = 4'd1;  // allocate: read a target row
	localparam logic [3:0] ST_ACHK  = 4'd2;  // allocate: check it is empty
	localparam logic [3:0] ST_AWR   = 4'd3;  // allocate: write a block row
	localparam logic [3:0] ST_RRD   = 4'd4;  // remove: read a block row
	localparam logic [3:0] ST_RCHK  = 4'd5;  // remove: check start flag
	localparam logic [3:0] ST_RWR   = 4'd6;  // remove: write the row back cleared
	localparam logic [3:0] ST_CRD   = 4'd7;  // compact: read scan row
	localparam logic [3:0] ST_CCHK  = 4'd8;  // compact: decide keep or move
	localparam logic [3:0] ST_CMRD  = 4'd9;  // compact: read a source row
	localparam logic [3:0] ST_CMDST = 4'd10; // compact: write it at the fill row
	localparam logic [3:0] ST_CMCLR = 4'd11; // compact: clear the source row
	localparam logic [3:0] ST_QRD   = 4'd12; // read: issue row read
	localparam logic [3:0] ST_QCHK  = 4'd13; // read: capture row
	localparam logic [3:0] ST_DONE  = 4'd14; // hand result to output register

	logic [3:0]        state_q;
	logic [AW-1:0]     pos_q;
	logic [3:0]        len_q;
	logic [31:0]       w0_q;
	logic [31:0]       w1_q;
	logic [31:0]       w2_q;
	logic [2:0]        need_q;
	logic [1:0]        cnt_q;
	logic [CW-1:0]     scan_q;
	logic [CW-1:0]     fill_q;
	logic [1:0]        res_status_q;
	rac_pkg::rac_row_t res_row_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	rac_pkg::rac_row_t row_q;

	// Memory port
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	rac_pkg::rac_row_t rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	rac_pkg::rac_row_t wr_data;

	rac_mem #(
		.ROWS(ROWS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Command decode at accept
	logic [rac_pkg::POS_W:0] pos_ext;
	logic [2:0]              in_need;
	logic                    pos_ok;
	logic                    len_ok;
	logic                    alloc_fits;

	assign pos_ext    = {1'b0, position};
	assign in_need    = rac_pkg::rows_of(length);
	assign pos_ok     = pos_ext < ROWS_P;
	assign len_ok     = (length != 4'd0) && (length <= rac_pkg::MAX_BYTES);
	assign alloc_fits = (pos_ext + (rac_pkg::POS_W + 1)'(in_need)) <= ROWS_P;

	// Row pointers and counters
	logic [CW-1:0] pos_cnt;
	logic [CW-1:0] scan_cnt;
	logic [2:0]    cnt_inc;
	logic [3:0]    bytes_left;
	logic [31:0]   alloc_word;
	logic [2:0]    scan_rows;

	assign pos_cnt    = CW'(pos_q) + CW'(cnt_q);
	assign scan_cnt   = scan_q + CW'(cnt_q);
	assign cnt_inc    = {1'b0, cnt_q} + 3'd1;
	assign bytes_left = len_q - {cnt_q, 2'b00};
	assign scan_rows  = rac_pkg::rows_of(rd_data.len);

	always_comb begin
		unique case (cnt_q)
			2'd0: alloc_word = w0_q;
			2'd1: alloc_word = w1_q;
			default: alloc_word = w2_q;
		endcase
	end

	// Drive the memory port from the current state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_ARD, ST_RRD, ST_QRD: begin
				rd_en   = 1'b1;
				rd_addr = pos_cnt[AW-1:0];
			end
			ST_AWR: begin
				wr_en        = 1'b1;
				wr_addr      = pos_cnt[AW-1:0];
				wr_data.word = alloc_word & rac_pkg::byte_mask(bytes_left);
				if (cnt_q == 2'd0) begin
					wr_data.start = 1'b1;
					wr_data.len   = len_q;
				end
			end
			ST_RWR: begin
				// start row loses its frame entry; later rows keep theirs
				wr_en   = 1'b1;
				wr_addr = pos_cnt[AW-1:0];
				if (cnt_q != 2'd0) begin
					wr_data.start = rd_data.start;
					wr_data.len   = rd_data.len;
				end
			end
			ST_CRD: begin
				rd_en   = scan_q < ROWS_C;
				rd_addr = scan_q[AW-1:0];
			end
			ST_CMRD: begin
				rd_en   = 1'b1;
				rd_addr = scan_cnt[AW-1:0];
			end
			ST_CMDST: begin
				wr_en   = 1'b1;
				wr_addr = fill_q[AW-1:0];
				wr_data = rd_data;
			end
			ST_CMCLR: begin
				wr_en   = 1'b1;
				wr_addr = scan_cnt[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			len_q        <= '0;
			w0_q         <= '0;
			w1_q         <= '0;
			w2_q         <= '0;
			need_q       <= '0;
			cnt_q        <= '0;
			scan_q       <= '0;
			fill_q       <= '0;
			res_status_q <= rac_pkg::STAT_OK;
			res_row_q    <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= rac_pkg::STAT_OK;
			row_q        <= '0;
		end else begin
			// drop the result beat once taken; completion reloads it on its own
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pos_q        <= position[AW-1:0];
						len_q        <= length;
						w0_q         <= word_first;
						w1_q         <= word_second;
						w2_q         <= word_third;
						need_q       <= in_need;
						cnt_q        <= '0;
						scan_q       <= '0;
						fill_q       <= '0;
						res_row_q    <= '0;
						unique case (action)
							rac_pkg::ACT_ALLOC: begin
								if (!pos_ok || !len_ok) begin
									res_status_q <= rac_pkg::STAT_RANGE;
									state_q      <= ST_DONE;
								end else if (!alloc_fits) begin
									res_status_q <= rac_pkg::STAT_NO_ROOM;
									state_q      <= ST_DONE;
								end else begin
									res_status_q <= rac_pkg::STAT_OK;
									state_q      <= ST_ARD;
								end
							end
							rac_pkg::ACT_REMOVE: begin
								if (!pos_ok) begin
									res_status_q <= rac_pkg::STAT_RANGE;
									state_q      <= ST_DONE;
								end else begin
									res_status_q <= rac_pkg::STAT_OK;
									state_q      <= ST_RRD;
								end
							end
							rac_pkg::ACT_COMPACT: begin
								res_status_q <= rac_pkg::STAT_OK;
								state_q      <= ST_CRD;
							end
							rac_pkg::ACT_READ: begin
								if (!pos_ok) begin
									res_status_q <= rac_pkg::STAT_RANGE;
									state_q      <= ST_DONE;
								end else begin
									res_status_q <= rac_pkg::STAT_OK;
									state_q      <= ST_QRD;
								end
							end
						endcase
					end
				end
				ST_ARD: state_q <= ST_ACHK;
				ST_ACHK: begin
					if (rd_data.word[7:0] != 8'd0) begin
						res_status_q <= rac_pkg::STAT_NO_ROOM;
						state_q      <= ST_DONE;
					end else if (cnt_inc == need_q) begin
						cnt_q   <= '0;
						state_q <= ST_AWR;
					end else begin
						cnt_q   <= cnt_inc[1:0];
						state_q <= ST_ARD;
					end
				end
				ST_AWR: begin
					if (cnt_inc == need_q) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_inc[1:0];
					end
				end
				ST_RRD: state_q <= ST_RCHK;
				ST_RCHK: begin
					if (cnt_q == 2'd0 && !rd_data.start) begin
						res_status_q <= rac_pkg::STAT_NO_BLOCK;
						state_q      <= ST_DONE;
					end else begin
						if (cnt_q == 2'd0) begin
							need_q <= scan_rows;
						end
						state_q <= ST_RWR;
					end
				end
				ST_RWR: begin
					if (cnt_inc < need_q && (pos_cnt + CW'(1)) < ROWS_C) begin
						cnt_q   <= cnt_inc[1:0];
						state_q <= ST_RRD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CRD: begin
					if (scan_q == ROWS_C) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CCHK;
					end
				end
				ST_CCHK: begin
					if (!rd_data.start) begin
						scan_q  <= scan_q + CW'(1);
						state_q <= ST_CRD;
					end else if (fill_q >= scan_q) begin
						// block stays; push the fill point past its end
						if ((scan_q + CW'(scan_rows)) > fill_q) begin
							fill_q <= scan_q + CW'(scan_rows);
						end
						scan_q  <= scan_q + CW'(1);
						state_q <= ST_CRD;
					end else begin
						need_q  <= scan_rows;
						cnt_q   <= '0;
						state_q <= ST_CMRD;
					end
				end
				ST_CMRD:  state_q <= ST_CMDST;
				ST_CMDST: state_q <= ST_CMCLR;
				ST_CMCLR: begin
					fill_q <= fill_q + CW'(1);
					if (cnt_inc < need_q && (scan_cnt + CW'(1)) < ROWS_C) begin
						cnt_q   <= cnt_inc[1:0];
						state_q <= ST_CMRD;
					end else begin
						scan_q  <= scan_q + CW'(1);
						state_q <= ST_CRD;
					end
				end
				ST_QRD: state_q <= ST_QCHK;
				ST_QCHK: begin
					res_row_q <= rd_data;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free or being emptied
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						row_q       <= res_row_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall     = state_q != ST_IDLE;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign row_word     = row_q.word;
	assign block_start  = row_q.start;
	assign block_length = row_q.len;

`ifndef SYNTHESIS
	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("memory read and write in the same cycle");

	a_rd_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (CW'(rd_addr) < ROWS_C))
		else $error("memory read beyond last row");

	a_wr_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CW'(wr_addr) < ROWS_C))
		else $error("memory write beyond last row");

	a_move_below_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMDST) |-> (fill_q < scan_cnt))
		else $error("compaction destination not below source");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("command taken without going busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside completion");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_row_allocator_with_compaction.sv =====
module tb_row_allocator_with_compaction;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS      = 16;
	localparam int ITEMS     = 1500;
	// Watchdog bound: far above the slowest beat, a full compaction, plus the
	// largest sender gap and receiver stall.
	localparam int LIMIT     = 1_000_000;
	localparam int TAIL      = 100;
	localparam int LOUD_ERRS = 40;

	// One command beat as the block sees it on its input ports.
	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  pos;
		logic [3:0]  len;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
	} command_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] word;
		logic        start;
		logic [3:0]  len;
	} result_t;

	// Mirror of the row store and frame table, plus the results still owed.
	class alloc_scoreboard;
		logic [31:0] store_word[ROWS];
		logic        store_start[ROWS];
		logic [3:0]  store_len[ROWS];
		result_t     awaited[$];
		int          errors;
		int          act_seen[4];
		int          stat_seen[4];

		function new();
			for (int i = 0; i < ROWS; i++) begin
				store_word[i]  = '0;
				store_start[i] = 1'b0;
				store_len[i]   = '0;
			end
			errors = 0;
			for (int i = 0; i < 4; i++) begin
				act_seen[i]  = 0;
				stat_seen[i] = 0;
			end
		endfunction

		function int row_span(logic [3:0] len);
			if (len == 4'd0)
				return 1;
			return (int'(len) + 3) / 4;
		endfunction

		function logic [1:0] place_block(command_t c);
			int          need;
			int          bytes;
			logic [31:0] w;
			logic [31:0] src[3];
			if (c.pos >= ROWS || c.len == 4'd0 || c.len > rac_pkg::MAX_BYTES)
				return rac_pkg::STAT_RANGE;
			need = row_span(c.len);
			if (int'(c.pos) + need > ROWS)
				return rac_pkg::STAT_NO_ROOM;
			for (int r = 0; r < need; r++)
				if (store_word[c.pos + r][7:0] != 8'h00)
					return rac_pkg::STAT_NO_ROOM;
			src[0] = c.w0;
			src[1] = c.w1;
			src[2] = c.w2;
			for (int r = 0; r < need; r++) begin
				bytes = int'(c.len) - 4 * r;
				w = src[r];
				// zero the bytes past the length in the last row
				if (bytes < 4)
					w &= (32'h1 << (8 * bytes)) - 32'h1;
				store_word[c.pos + r]  = w;
				store_start[c.pos + r] = 1'b0;
				store_len[c.pos + r]   = '0;
			end
			store_start[c.pos] = 1'b1;
			store_len[c.pos]   = c.len;
			return rac_pkg::STAT_OK;
		endfunction

		function logic [1:0] free_block(logic [7:0] pos);
			int need;
			if (pos >= ROWS)
				return rac_pkg::STAT_RANGE;
			if (!store_start[pos])
				return rac_pkg::STAT_NO_BLOCK;
			need = row_span(store_len[pos]);
			for (int r = 0; r < need && int'(pos) + r < ROWS; r++)
				store_word[pos + r] = '0;
			store_start[pos] = 1'b0;
			store_len[pos]   = '0;
			return rac_pkg::STAT_OK;
		endfunction

		function void squeeze();
			int fill;
			int n;
			fill = 0;
			for (int i = 0; i < ROWS; i++) begin
				if (!store_start[i])
					continue;
				n = row_span(store_len[i]);
				// a start at or under the fill point stays where it is
				if (fill >= i) begin
					if (i + n > fill)
						fill = i + n;
					continue;
				end
				for (int j = 0; j < n && i + j < ROWS; j++) begin
					store_word[fill]  = store_word[i + j];
					store_start[fill] = store_start[i + j];
					store_len[fill]   = store_len[i + j];
					store_word[i + j]  = '0;
					store_start[i + j] = 1'b0;
					store_len[i + j]   = '0;
					fill++;
				end
			end
		endfunction

		function result_t predict(command_t c);
			result_t res;
			res = '0;
			case (c.act)
				rac_pkg::ACT_ALLOC: res.status = place_block(c);
				rac_pkg::ACT_REMOVE: res.status = free_block(c.pos);
				rac_pkg::ACT_COMPACT: squeeze();
				default: begin
					if (c.pos >= ROWS) begin
						res.status = rac_pkg::STAT_RANGE;
					end else begin
						res.word  = store_word[c.pos];
						res.start = store_start[c.pos];
						res.len   = store_len[c.pos];
					end
				end
			endcase
			return res;
		endfunction

		function void note_command(command_t c);
			act_seen[c.act]++;
			awaited.push_back(predict(c));
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Random row that holds a block start, or -1 if there is none.
		function int pick_start();
			int starts[$];
			for (int i = 0; i < ROWS; i++)
				if (store_start[i])
					starts.push_back(i);
			if (starts.size() == 0)
				return -1;
			return starts[$urandom_range(0, starts.size() - 1)];
		endfunction

		task report(string msg);
			errors++;
			if (errors <= LOUD_ERRS)
				$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		task check_result(result_t got);
			result_t want;
			stat_seen[got.status]++;
			if (awaited.size() == 0) begin
				report($sformatf("result beat with none awaited (status %0d)", got.status));
			end else begin
				want = awaited.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.word !== want.word)
					report($sformatf("row_word %h, want %h", got.word, want.word));
				if (got.start !== want.start)
					report($sformatf("block_start %b, want %b", got.start, want.start));
				if (got.len !== want.len)
					report($sformatf("block_length %0d, want %0d", got.len, want.len));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [7:0]  position;
	logic [3:0]  length;
	logic [31:0] word_first;
	logic [31:0] word_second;
	logic [31:0] word_third;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] row_word;
	logic        block_start;
	logic [3:0]  block_length;

	alloc_scoreboard board = new();

	// Idle modes: when clear, that side runs back to back.
	bit in_idle  = 1'b1;
	bit out_idle = 1'b1;
	int cycles   = 0;

	row_allocator_with_compaction #(
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.position(position),
		.length(length),
		.word_first(word_first),
		.word_second(word_second),
		.word_third(word_third),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.row_word(row_word),
		.block_start(block_start),
		.block_length(block_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				board.pending());
			$display("tb_row_allocator_with_compaction: errors");
			$finish;
		end
	end

	function int draw_gap(bit busy);
		return busy ? $urandom_range(0, 11) : 0;
	endfunction

	function command_t mk(logic [1:0] act, logic [7:0] pos, logic [3:0] len,
			logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
		command_t c;
		c.act = act;
		c.pos = pos;
		c.len = len;
		c.w0  = w0;
		c.w1  = w1;
		c.w2  = w2;
		return c;
	endfunction

	// Mostly well-formed commands on live rows; a slice of raw noise covers the
	// out-of-range positions and the bad lengths.
	function command_t random_command();
		command_t c;
		int       pick;
		int       s;
		pick = $urandom_range(0, 99);
		c.w0 = $urandom;
		c.w1 = $urandom;
		c.w2 = $urandom;
		// a zero first byte leaves the row looking empty, which lets blocks overlap
		if ($urandom_range(0, 9) == 0)
			c.w0[7:0] = 8'h00;
		else if (c.w0[7:0] == 8'h00)
			c.w0[0] = 1'b1;
		c.pos = 8'($urandom_range(0, ROWS - 1));
		c.len = 4'($urandom_range(1, rac_pkg::MAX_BYTES));
		if (pick < 8) begin
			c.act = 2'($urandom_range(0, 3));
			c.pos = 8'($urandom_range(0, 255));
			c.len = 4'($urandom_range(0, 15));
		end else if (pick < 50) begin
			c.act = rac_pkg::ACT_ALLOC;
		end else if (pick < 70) begin
			c.act = rac_pkg::ACT_REMOVE;
			s = board.pick_start();
			if (s >= 0 && $urandom_range(0, 4) != 0)
				c.pos = 8'(s);
		end else if (pick < 93) begin
			c.act = rac_pkg::ACT_READ;
		end else begin
			c.act = rac_pkg::ACT_COMPACT;
		end
		return c;
	endfunction

	// Enter right after a rising edge; leave at the edge that took the beat.
	task automatic send_beat(command_t c);
		int gap;
		gap = draw_gap(in_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= c.act;
		position    <= c.pos;
		length      <= c.len;
		word_first  <= c.w0;
		word_second <= c.w1;
		word_third  <= c.w2;
		// hold the payload until an edge sees valid with no stall
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		board.note_command(c);
	endtask

	// Drop valid and hold off until every owed result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	// Result side: stall for a drawn number of cycles, then take one beat.
	initial begin
		int gap;
		int taken;
		out_stall = 1'b0;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// redraw whether to stall or stream every 200 beats
			if (taken % 200 == 0)
				out_idle = $urandom_range(0, 2) != 0;
			gap = draw_gap(out_idle);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			board.check_result('{status, row_word, block_start, block_length});
			taken++;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = rac_pkg::ACT_READ;
		position    = '0;
		length      = '0;
		word_first  = '0;
		word_second = '0;
		word_third  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, range edges, bad lengths, padding, overlap.
		send_beat(mk(rac_pkg::ACT_READ, 8'd0, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_READ, 8'd15, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_READ, 8'd16, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_READ, 8'd255, 4'd15, '1, '1, '1));
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd0, 4'd0, '1, '1, '1));
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd0, 4'd13, '1, '1, '1));
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd0, 4'd15, '1, '1, '1));
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd16, 4'd4, '1, '1, '1));
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd255, 4'd12, '1, '1, '1));
		// full-size block in the first rows, then a collision with it
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd0, 4'd12, '1, '1, '1));
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd1, 4'd1, 32'h0000_0011, '0, '0));
		// would run past the last row; then one that just fits in the last row
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd14, 4'd12, '1, '1, '1));
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd15, 4'd4, '1, '1, '1));
		// one-byte block: upper bytes padded with zero
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd5, 4'd1, 32'h1234_5678, '1, '1));
		// zero first byte in the second row: row 8 still counts as empty, so it is reused
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd7, 4'd7, 32'h00AB_CDEF, 32'hFF11_2200, '1));
		send_beat(mk(rac_pkg::ACT_ALLOC, 8'd8, 4'd2, 32'hFFFF_3344, '0, '0));
		send_beat(mk(rac_pkg::ACT_READ, 8'd8, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_REMOVE, 8'd6, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_REMOVE, 8'd16, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_REMOVE, 8'd0, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_READ, 8'd1, 4'd0, '0, '0, '0));
		// compaction with overlapping blocks, position and length ignored
		send_beat(mk(rac_pkg::ACT_COMPACT, 8'd255, 4'd15, '1, '1, '1));
		send_beat(mk(rac_pkg::ACT_READ, 8'd0, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_READ, 8'd3, 4'd0, '0, '0, '0));
		send_beat(mk(rac_pkg::ACT_COMPACT, 8'd0, 4'd0, '0, '0, '0));

		// Random: well-formed traffic with some noise; idle mode flips in phases.
		for (int k = 0; k < ITEMS; k++) begin
			if (k % 150 == 0)
				in_idle = $urandom_range(0, 3) != 0;
			if (k == ITEMS / 2)
				drain();
			send_beat(random_command());
		end
		in_valid <= 1'b0;

		// Wait out the owed results, then watch for strays a while longer.
		do
			@(posedge clk);
		while (board.pending() != 0);
		repeat (TAIL) @(posedge clk);

		$display("beats sent: alloc %0d, remove %0d, compact %0d, read %0d",
			board.act_seen[rac_pkg::ACT_ALLOC], board.act_seen[rac_pkg::ACT_REMOVE],
			board.act_seen[rac_pkg::ACT_COMPACT], board.act_seen[rac_pkg::ACT_READ]);
		$display("results: ok %0d, no room %0d, no block %0d, range %0d; %0d mismatches",
			board.stat_seen[rac_pkg::STAT_OK], board.stat_seen[rac_pkg::STAT_NO_ROOM],
			board.stat_seen[rac_pkg::STAT_NO_BLOCK], board.stat_seen[rac_pkg::STAT_RANGE],
			board.errors);
		if (board.errors == 0) begin
			$display("tb_row_allocator_with_compaction: clean");
		end else begin
			$display("tb_row_allocator_with_compaction: errors");
		end
		$finish;
	end

endmodule
